>>> hw/rtl/amm_pkg.sv
// package: shared widths, constants and sequencer states for the adjacent merge cost block
`timescale 1ns / 1ps

package amm_pkg;

    // fixed field widths
    localparam int SIZE_W = 32;
    localparam int COST_W = 46;

    // saturation ceiling of the reported cost
    localparam logic [COST_W-1:0] COST_MAX = '1;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SPAN_RD,
        ST_SPAN_CALC,
        ST_SPLIT,
        ST_DRAIN,
        ST_WRITE,
        ST_FINAL_RD,
        ST_FINAL
    } t_state;

endpackage

>>> hw/rtl/amm_ram.sv
// generic single-write, dual-read memory with registered read data
`timescale 1ns / 1ps

module amm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read ports
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

>>> hw/rtl/adjacent_merge_min_cost.sv
// Adjacent merge minimum cost: sizes arrive one per transaction and are kept as running
// prefix sums; the transaction flagged last starts a bottom-up fill of the interval cost
// table and one result (least merge cost, too-many flag) follows. A transaction without
// last leaves the block idle. After the last one, the single-element intervals are
// cleared in state INIT; then each interval is handled in the states SPAN_RD, SPAN_CALC,
// SPLIT, DRAIN and WRITE, where one split point is evaluated per cycle in SPLIT through
// the single adder and comparator, fed by the two read ports of the interval table. The
// states FINAL_RD and FINAL read out the final entry. An earlier result still held in the
// output register delays the hand-off further. Input stall is high for that whole
// stretch. Elements beyond MAX_ITEMS are dropped and flagged; min_cost saturates at
// 2^46 - 1.
`timescale 1ns / 1ps

module adjacent_merge_min_cost #(
    parameter int MAX_ITEMS = 128
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [amm_pkg::SIZE_W-1:0] i_size,
    input  logic                       i_last,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [amm_pkg::COST_W-1:0] o_min_cost,
    output logic                       o_too_many
);

    localparam int IW   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNTW = $clog2(MAX_ITEMS + 1);
    localparam int JW   = CNTW + 1;
    localparam int PW   = amm_pkg::SIZE_W + ((MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 0);
    localparam int CW   = PW + IW + 1;
    localparam int EW   = (CW > amm_pkg::COST_W) ? CW : amm_pkg::COST_W;
    localparam int TAW  = 2 * IW;

    amm_pkg::t_state r_state, n_state;

    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            r_ovf, n_ovf;
    logic [PW-1:0]   r_psum, n_psum;
    logic [CNTW-1:0] r_n, n_n;
    logic            r_many, n_many;
    logic [CNTW-1:0] r_len, n_len;
    logic [IW-1:0]   r_i, n_i;
    logic [IW-1:0]   r_k, n_k;
    logic [PW-1:0]   r_span, n_span;
    logic [CW-1:0]   r_low, n_low;
    logic            r_cmp_v, n_cmp_v;
    logic            r_out_valid, n_out_valid;
    logic [amm_pkg::COST_W-1:0] r_out_cost, n_out_cost;
    logic            r_out_many, n_out_many;

    // memory ports
    logic            w_p_we;
    logic [IW-1:0]   w_p_waddr, w_p_ra, w_p_rb;
    logic [PW-1:0]   w_p_wdata, w_p_qa, w_p_qb;
    logic            w_b_we;
    logic [TAW-1:0]  w_b_waddr, w_b_ra, w_b_rb;
    logic [CW-1:0]   w_b_wdata, w_b_qa, w_b_qb;

    // helpers
    logic            w_in_acc, w_room, w_out_free;
    logic [PW-1:0]   w_new_sum;
    logic [JW-1:0]   w_j_ext, w_ni_ext;
    logic [IW-1:0]   w_j, w_last_idx;
    logic [CW-1:0]   w_sab;
    logic [EW-1:0]   w_fin_ext;
    logic [amm_pkg::COST_W-1:0] w_fin_sat;

    // prefix sums: entry m-1 holds the sum of the first m sizes
    amm_ram #(.WIDTH(PW), .DEPTH(MAX_ITEMS), .AW(IW)) u_prefix (
        .i_clk     (i_clk),
        .i_we      (w_p_we),
        .i_waddr   (w_p_waddr),
        .i_wdata   (w_p_wdata),
        .i_raddr_a (w_p_ra),
        .i_raddr_b (w_p_rb),
        .o_rdata_a (w_p_qa),
        .o_rdata_b (w_p_qb)
    );

    // interval cost table addressed by {first, last}
    amm_ram #(.WIDTH(CW), .DEPTH(1 << TAW), .AW(TAW)) u_best (
        .i_clk     (i_clk),
        .i_we      (w_b_we),
        .i_waddr   (w_b_waddr),
        .i_wdata   (w_b_wdata),
        .i_raddr_a (w_b_ra),
        .i_raddr_b (w_b_rb),
        .o_rdata_a (w_b_qa),
        .o_rdata_b (w_b_qb)
    );

    // handshake and shared arithmetic
    assign o_stall    = (r_state != amm_pkg::ST_IDLE);
    assign w_in_acc   = i_valid && !o_stall;
    assign w_room     = (r_cnt < CNTW'(MAX_ITEMS));
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_new_sum  = r_psum + PW'(i_size);
    assign w_j_ext    = JW'(r_i) + JW'(r_len) - JW'(1);
    assign w_j        = w_j_ext[IW-1:0];
    assign w_ni_ext   = JW'(r_i) + JW'(1);
    assign w_last_idx = IW'(r_n - CNTW'(1));
    assign w_sab      = w_b_qa + w_b_qb;
    assign w_fin_ext  = EW'(w_b_qa);
    assign w_fin_sat  = (w_fin_ext > EW'(amm_pkg::COST_MAX)) ? amm_pkg::COST_MAX
                                                            : w_fin_ext[amm_pkg::COST_W-1:0];

    // sequencer: next state, counters and memory control
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_psum      = r_psum;
        n_n         = r_n;
        n_many      = r_many;
        n_len       = r_len;
        n_i         = r_i;
        n_k         = r_k;
        n_span      = r_span;
        n_low       = r_low;
        n_cmp_v     = 1'b0;
        n_out_valid = r_out_valid && i_stall;
        n_out_cost  = r_out_cost;
        n_out_many  = r_out_many;

        w_p_we    = 1'b0;
        w_p_waddr = r_cnt[IW-1:0];
        w_p_wdata = w_new_sum;
        w_p_ra    = r_i - IW'(1);
        w_p_rb    = w_j;
        w_b_we    = 1'b0;
        w_b_waddr = {r_i, w_j};
        w_b_wdata = r_low + CW'(r_span);
        w_b_ra    = {r_i, r_k};
        w_b_rb    = {r_k + IW'(1), w_j};

        // running minimum over split candidates, in the cycle after the reads
        if (r_cmp_v && (w_sab < r_low)) begin
            n_low = w_sab;
        end

        case (r_state)
            amm_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    if (w_room) begin
                        w_p_we = 1'b1;
                        n_psum = w_new_sum;
                        n_cnt  = r_cnt + CNTW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last) begin
                        n_n     = w_room ? (r_cnt + CNTW'(1)) : r_cnt;
                        n_many  = r_ovf || !w_room;
                        n_k     = '0;
                        n_state = amm_pkg::ST_INIT;
                    end
                end
            end
            amm_pkg::ST_INIT: begin
                // zero the single-element intervals
                w_b_we    = 1'b1;
                w_b_waddr = {r_k, r_k};
                w_b_wdata = '0;
                if (r_k == w_last_idx) begin
                    n_len   = CNTW'(2);
                    n_i     = '0;
                    n_state = (r_n < CNTW'(2)) ? amm_pkg::ST_FINAL_RD : amm_pkg::ST_SPAN_RD;
                end else begin
                    n_k = r_k + IW'(1);
                end
            end
            amm_pkg::ST_SPAN_RD: begin
                n_state = amm_pkg::ST_SPAN_CALC;
            end
            amm_pkg::ST_SPAN_CALC: begin
                n_span  = w_p_qb - ((r_i == '0) ? PW'(0) : w_p_qa);
                n_low   = '1;
                n_k     = r_i;
                n_state = amm_pkg::ST_SPLIT;
            end
            amm_pkg::ST_SPLIT: begin
                // issue one split point per cycle
                n_cmp_v = 1'b1;
                if (r_k == (w_j - IW'(1))) begin
                    n_state = amm_pkg::ST_DRAIN;
                end else begin
                    n_k = r_k + IW'(1);
                end
            end
            amm_pkg::ST_DRAIN: begin
                n_state = amm_pkg::ST_WRITE;
            end
            amm_pkg::ST_WRITE: begin
                w_b_we = 1'b1;
                if ((w_ni_ext + JW'(r_len)) > JW'(r_n)) begin
                    if (r_len == r_n) begin
                        n_state = amm_pkg::ST_FINAL_RD;
                    end else begin
                        n_len   = r_len + CNTW'(1);
                        n_i     = '0;
                        n_state = amm_pkg::ST_SPAN_RD;
                    end
                end else begin
                    n_i     = w_ni_ext[IW-1:0];
                    n_state = amm_pkg::ST_SPAN_RD;
                end
            end
            amm_pkg::ST_FINAL_RD: begin
                w_b_ra  = {IW'(0), w_last_idx};
                n_state = amm_pkg::ST_FINAL;
            end
            amm_pkg::ST_FINAL: begin
                w_b_ra = {IW'(0), w_last_idx};
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_cost  = w_fin_sat;
                    n_out_many  = r_many;
                    n_cnt       = '0;
                    n_ovf       = 1'b0;
                    n_psum      = '0;
                    n_state     = amm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = amm_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= amm_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_psum      <= '0;
            r_cmp_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_psum      <= n_psum;
            r_cmp_v     <= n_cmp_v;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_many     <= n_many;
        r_len      <= n_len;
        r_i        <= n_i;
        r_k        <= n_k;
        r_span     <= n_span;
        r_low      <= n_low;
        r_out_cost <= n_out_cost;
        r_out_many <= n_out_many;
    end

    // output register
    assign o_valid    = r_out_valid;
    assign o_min_cost = r_out_cost;
    assign o_too_many = r_out_many;

    // stored element count never passes the capacity
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNTW'(MAX_ITEMS))
        else $error("element count beyond capacity");

    // split index stays inside its interval
    a_split_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == amm_pkg::ST_SPLIT) |-> (r_k < w_j))
        else $error("split index out of interval");

    // every interval written has seen at least one candidate
    a_low_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == amm_pkg::ST_WRITE) |-> (r_low != '1))
        else $error("interval written without a candidate");

    // a new result only comes from the final state
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == amm_pkg::ST_FINAL))
        else $error("result raised outside final state");

endmodule

>>> test/amm_checker.sv
// checker: watches both channels of the adjacent merge cost block, predicts and compares results
`timescale 1ns / 1ps

module amm_checker #(
    parameter int MAX_ITEMS = 128
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic [amm_pkg::SIZE_W-1:0] i_size,
    input  logic                       i_last,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [amm_pkg::COST_W-1:0] i_min_cost,
    input  logic                       i_too_many,
    output int                         o_fail_count,
    output int                         o_open_count,
    output int                         o_checked_count
);

    localparam int                COST_W   = amm_pkg::COST_W;
    localparam logic [COST_W-1:0] COST_MAX = amm_pkg::COST_MAX;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic              too_many;
    } t_merge_result;

    // predicted state of the block
    int          elem_count   = 0;
    logic        dropped_seen = 1'b0;
    logic [38:0] run_sum [0:MAX_ITEMS];
    logic [63:0] cost_tab [0:MAX_ITEMS-1][0:MAX_ITEMS-1];

    t_merge_result pending_costs[$];
    int            fail_total    = 0;
    int            checked_total = 0;

    // one line per mismatch, counted
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
        fail_total++;
    endtask

    // bottom-up interval fill over the stored running sums, saturated to the cost width
    function automatic logic [COST_W-1:0] merge_cost(input int n);
        logic [63:0] low;
        logic [63:0] span;
        logic [63:0] c;
        int          len;
        int          a;
        int          b;
        int          k;
        for (a = 0; a < n; a++) cost_tab[a][a] = '0;
        for (len = 2; len <= n; len++) begin
            for (a = 0; a + len <= n; a++) begin
                b    = a + len - 1;
                span = 64'(run_sum[b + 1] - run_sum[a]);
                low  = '1;
                for (k = a; k < b; k++) begin
                    c = cost_tab[a][k] + cost_tab[k + 1][b] + span;
                    if (c < low) low = c;
                end
                cost_tab[a][b] = low;
            end
        end
        if (cost_tab[0][n - 1] > {18'd0, COST_MAX}) return COST_MAX;
        return cost_tab[0][n - 1][COST_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        t_merge_result want;
        if (!i_rst_n) begin
            elem_count   = 0;
            dropped_seen = 1'b0;
            run_sum[0]   = '0;
            pending_costs.delete();
        end else begin
            // accepted input transaction
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0) begin
                if (elem_count < MAX_ITEMS) begin
                    run_sum[elem_count + 1] = run_sum[elem_count] + 39'(i_size);
                    elem_count++;
                end else begin
                    dropped_seen = 1'b1;
                end
                if (i_last) begin
                    want.cost     = merge_cost(elem_count);
                    want.too_many = dropped_seen;
                    pending_costs = {pending_costs, want};
                    elem_count   = 0;
                    dropped_seen = 1'b0;
                end
            end
            // accepted result transaction against the oldest prediction
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (pending_costs.size() == 0) begin
                    report_mismatch("result with none outstanding, min_cost", 64'(i_min_cost),
                                    64'd0);
                end else begin
                    want = pending_costs.pop_front();
                    if (i_min_cost !== want.cost)
                        report_mismatch("min_cost", 64'(i_min_cost), 64'(want.cost));
                    if (i_too_many !== want.too_many)
                        report_mismatch("too_many", 64'(i_too_many), 64'(want.too_many));
                    checked_total++;
                end
            end
        end
        o_fail_count    <= fail_total;
        o_open_count    <= pending_costs.size();
        o_checked_count <= checked_total;
    end

endmodule

>>> test/tb_adjacent_merge_min_cost.sv
// testbench top: stimulus, channel idling and verdict for the adjacent merge cost block
`timescale 1ns / 1ps

module tb_adjacent_merge_min_cost;

    localparam int SIZE_W = amm_pkg::SIZE_W;
    localparam int COST_W = amm_pkg::COST_W;

    localparam int MAX_ELEMS = 128;
    localparam int HOLD_CYCLES = 400;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [SIZE_W-1:0] i_size;
    logic              i_last;
    logic              o_valid;
    logic              i_stall;
    logic [COST_W-1:0] o_min_cost;
    logic              o_too_many;

    int fail_count;
    int open_count;
    int checked_count;

    int burst_left;
    int items_sent;
    int sequences_sent;
    int longest_seq;
    int dropped_total;

    adjacent_merge_min_cost #(.MAX_ITEMS(MAX_ELEMS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_size     (i_size),
        .i_last     (i_last),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_min_cost (o_min_cost),
        .o_too_many (o_too_many)
    );

    amm_checker #(.MAX_ITEMS(MAX_ELEMS)) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_size          (i_size),
        .i_last          (i_last),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_min_cost      (o_min_cost),
        .i_too_many      (o_too_many),
        .o_fail_count    (fail_count),
        .o_open_count    (open_count),
        .o_checked_count (checked_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // overall time limit, far beyond the slowest correct run
    initial begin
        #(64'd60_000_000);
        $display("tb: failure");
        $finish;
    end

    // size mix: zero, all ones, small, moderate and full random
    function automatic logic [SIZE_W-1:0] rand_size();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return SIZE_W'($urandom_range(0, 15));
            3: return SIZE_W'($urandom_range(0, 1000));
            default: return SIZE_W'($urandom());
        endcase
    endfunction

    // one input transaction, with bursts and random gaps on the sender side
    task automatic send_item(input logic [SIZE_W-1:0] size, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_size  <= size;
        i_last  <= last;
        do @(posedge i_clk); while (o_stall);
        burst_left--;
        items_sent++;
    endtask

    // a whole sequence; heavy leans towards full-scale sizes
    task automatic send_sequence(input int len, input logic heavy);
        int m;
        logic [SIZE_W-1:0] s;
        for (m = 0; m < len; m++) begin
            if (heavy && $urandom_range(0, 3) != 0) s = '1;
            else s = rand_size();
            send_item(s, m == len - 1);
        end
        sequences_sent++;
        if (len > longest_seq) longest_seq = len;
        if (len > MAX_ELEMS) dropped_total += len - MAX_ELEMS;
    endtask

    // receiver: one long hold-off early on, then its own stall pattern
    initial begin
        int mode;
        int run;
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        i_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        forever begin
            mode = $urandom_range(0, 2);
            run  = $urandom_range(5, 60);
            repeat (run) begin
                @(posedge i_clk);
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= 1'($urandom_range(0, 1));
                    default: i_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // stimulus and verdict
    initial begin
        int len;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_size         <= '0;
        i_last         <= 1'b0;
        burst_left     = 0;
        items_sent     = 0;
        sequences_sent = 0;
        longest_seq    = 0;
        dropped_total  = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: single elements at both extremes
        send_item('0, 1'b1);
        send_item('1, 1'b1);
        // two full-scale elements
        send_item('1, 1'b0);
        send_item('1, 1'b1);
        // a large element between zeros
        send_item('0, 1'b0);
        send_item('1, 1'b0);
        send_item('0, 1'b1);
        // small ascending run
        send_item(32'd1, 1'b0);
        send_item(32'd2, 1'b0);
        send_item(32'd3, 1'b1);
        // alternating extremes
        send_item('1, 1'b0);
        send_item('0, 1'b0);
        send_item('1, 1'b0);
        send_item('0, 1'b1);
        // all zeros
        repeat (3) send_item('0, 1'b0);
        send_item('0, 1'b1);
        // alternating bit patterns
        send_item(32'hAAAA_AAAA, 1'b0);
        send_item(32'h5555_5555, 1'b1);
        sequences_sent = 8;
        longest_seq    = 4;

        // random: mostly short sequences, now and then a longer one, and one
        // overlong sequence whose tail is dropped while its last flag still closes it
        while (items_sent < 210 || sequences_sent < 21) begin
            if (sequences_sent == 20) send_sequence(MAX_ELEMS + 2, 1'b1);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 16)
                                              : $urandom_range(1, 4);
            send_sequence(len, 1'b0);
        end
        i_valid <= 1'b0;

        // drain outstanding results, then a short settle
        @(posedge i_clk);
        while (open_count != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("summary: %0d sizes in %0d sequences, longest %0d with %0d dropped",
                 items_sent, sequences_sent, longest_seq, dropped_total);
        $display("summary: %0d results compared, receiver held off for %0d cycles",
                 checked_count, HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
